@@ hw/rtl/tcf_pkg.sv @@
package tcf_pkg;

  localparam int unsigned HIT_SPACE     = 65536;
  localparam int unsigned MAX_TRACK_LEN = 256;

  localparam int unsigned HIT_INDEX_W = 16;
  localparam int unsigned REG_W       = 9;
  localparam int unsigned RUNS_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned MAP_AW = $clog2(HIT_SPACE);
  localparam int unsigned BUF_AW = $clog2(MAX_TRACK_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_TRACK_LEN + 1);

  // coverage map entries hold the epoch in which they were set; 0 = wiped
  localparam int unsigned EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned Q_AW        = $clog2(QUEUE_DEPTH);

  localparam int unsigned PROD_W = REG_W + CNT_W;
  localparam int unsigned CMP_W  = (PROD_W > REG_W + 8) ? PROD_W : REG_W + 8;
  localparam int unsigned LEN_W  = (CNT_W > REG_W) ? CNT_W : REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_TRACK_LENGTH = 2'd0,
    REG_RUN_THRESHOLD    = 2'd1,
    REG_NEW_RATIO_Q8     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED = 2'd0,
    VERDICT_SHORT    = 2'd1,
    VERDICT_FILTERED = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_LAST  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [HIT_INDEX_W-1:0] hit_index;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

  typedef struct packed {
    logic [REG_W-1:0] min_track_length;
    logic [REG_W-1:0] run_threshold;
    logic [REG_W-1:0] new_ratio_q8;
  } cfg_t;

endpackage

@@ hw/rtl/tcf_in_if.sv @@
interface tcf_in_if import tcf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [HIT_INDEX_W-1:0] hit_index;
  logic                   last_hit;

  modport src (output valid, command, hit_index, last_hit, input ready);
  modport snk (input valid, command, hit_index, last_hit, output ready);
endinterface

@@ hw/rtl/tcf_out_if.sv @@
interface tcf_out_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        verdict;
  logic [REG_W-1:0]  track_length;
  logic [REG_W-1:0]  new_hit_count;
  logic [RUNS_W-1:0] run_count;

  modport src (output valid, verdict, track_length, new_hit_count, run_count, input ready);
  modport snk (input valid, verdict, track_length, new_hit_count, run_count, output ready);
endinterface

@@ hw/rtl/track_coverage_filter_unit.sv @@
// channel   | dir | payload                                            | role
// hits      | in  | command, hit_index[15:0], last_hit                 | hits / clear
// verdicts  | out | verdict[1:0], track_length[8:0], new_hit_count[8:0], run_count[7:0]
// cfg       | in  | cfg_we, cfg_index[1:0], cfg_wdata[8:0]             | register write
//
// In the back end a hit takes one coverage map read, then one scan update.
// The last hit adds a judge step; an accepted candidate adds a map write-back of
// its buffered hits, one buffered hit per cycle through the single map write port.
// Every 15th clear, and reset, runs a wipe of all 65536 map entries, during which
// transactions queue (4 deep) and then stall. Reset is synchronous.
module track_coverage_filter_unit import tcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  tcf_in_if.snk                hits,
  tcf_out_if.src               verdicts
);

  cfg_t    cfg;
  q_slot_t push;
  q_slot_t head;
  logic    q_full;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_track_length <= '0;
      cfg.run_threshold    <= REG_W'(1);
      cfg.new_ratio_q8     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_TRACK_LENGTH: cfg.min_track_length <= cfg_wdata;
        REG_RUN_THRESHOLD:    cfg.run_threshold    <= cfg_wdata;
        REG_NEW_RATIO_Q8:     cfg.new_ratio_q8     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcf_front u_front (
    .hits   (hits),
    .q_full (q_full),
    .push   (push)
  );

  tcf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  tcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .verdicts (verdicts)
  );

endmodule

@@ hw/rtl/tcf_ram.sv @@
module tcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tcf_front.sv @@
module tcf_front import tcf_pkg::*; (
  tcf_in_if.snk   hits,
  input  logic    q_full,
  output q_slot_t push
);

  op_t op;

  always_comb begin
    if (hits.command) begin
      op = OP_CLEAR;
    end else if (hits.last_hit) begin
      op = OP_LAST;
    end else begin
      op = OP_HIT;
    end
  end

  assign hits.ready          = !q_full;
  assign push.valid          = hits.valid && !q_full;
  assign push.entry.op       = op;
  assign push.entry.hit_index = hits.hit_index;

endmodule

@@ hw/rtl/tcf_queue.sv @@
module tcf_queue import tcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_slot_t push,
  output logic    full,
  input  logic    pop,
  output q_slot_t head
);

  q_entry_t        slots [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW + 1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tcf_back.sv @@
module tcf_back import tcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  q_slot_t head,
  output logic    pop,
  tcf_out_if.src  verdicts
);

  typedef enum logic [4:0] {
    S_WIPE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_JUDGE = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  localparam logic [REG_W-1:0]  SAT9 = '1;
  localparam logic [RUNS_W-1:0] SAT8 = '1;

  state_t state;

  logic [EPOCH_W-1:0] epoch;
  logic [MAP_AW-1:0]  wipe_ptr;

  logic [CNT_W-1:0]  hit_count;
  logic [REG_W-1:0]  new_count;
  logic [REG_W-1:0]  run_length;
  logic [RUNS_W-1:0] qualified_runs;
  logic              overflowed;
  logic              last_q;
  logic              in_range_q;

  logic [CNT_W-1:0] wb_ptr;
  logic [CNT_W-1:0] wb_len;
  logic             wb_rd_v;

  logic              out_valid;
  verdict_t          out_verdict;
  logic [REG_W-1:0]  out_len;
  logic [REG_W-1:0]  out_new;
  logic [RUNS_W-1:0] out_runs;

  logic                   map_we;
  logic [MAP_AW-1:0]      map_waddr;
  logic [EPOCH_W-1:0]     map_wdata;
  logic [MAP_AW-1:0]      map_raddr;
  logic [EPOCH_W-1:0]     map_rdata;
  logic                   buf_we;
  logic [BUF_AW-1:0]      buf_waddr;
  logic [BUF_AW-1:0]      buf_raddr;
  logic [HIT_INDEX_W-1:0] buf_rdata;

  logic              buf_full;
  logic              covered;
  logic              head_in_range;
  logic              wb_in_range;
  logic              out_free;
  logic [RUNS_W-1:0] runs_final;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  rhs;
  logic [PROD_W-1:0] prod;
  verdict_t          verdict;

  tcf_ram #(.WIDTH(EPOCH_W), .DEPTH(HIT_SPACE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tcf_ram #(.WIDTH(HIT_INDEX_W), .DEPTH(MAX_TRACK_LEN)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (head.entry.hit_index),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  assign head_in_range = (32'(head.entry.hit_index) < HIT_SPACE);
  assign wb_in_range   = (32'(buf_rdata) < HIT_SPACE);
  assign buf_full      = (hit_count == CNT_W'(MAX_TRACK_LEN));
  assign covered       = in_range_q && (map_rdata == epoch);
  assign out_free      = !out_valid || verdicts.ready;
  assign pop           = (state == S_FETCH) && head.valid;

  assign map_raddr = MAP_AW'(head.entry.hit_index);
  assign buf_waddr = BUF_AW'(hit_count);
  assign buf_raddr = BUF_AW'(wb_ptr);
  assign buf_we    = pop && (head.entry.op != OP_CLEAR) && !buf_full;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = wipe_ptr;
    map_wdata = '0;
    if (state == S_WIPE) begin
      map_we = 1'b1;
    end else if (state == S_WB && wb_rd_v) begin
      map_we    = wb_in_range;
      map_waddr = MAP_AW'(buf_rdata);
      map_wdata = epoch;
    end
  end

  always_comb begin
    runs_final = qualified_runs;
    if (run_length >= cfg.run_threshold && qualified_runs != SAT8) begin
      runs_final = qualified_runs + 1'b1;
    end
    prod = PROD_W'(cfg.new_ratio_q8) * PROD_W'(hit_count);
    lhs  = CMP_W'({new_count, 8'b0});
    rhs  = CMP_W'(prod);
    priority if (overflowed) begin
      verdict = VERDICT_OVERFLOW;
    end else if (LEN_W'(hit_count) < LEN_W'(cfg.min_track_length)) begin
      verdict = VERDICT_SHORT;
    end else if (lhs >= rhs && runs_final != '0) begin
      verdict = VERDICT_ACCEPTED;
    end else begin
      verdict = VERDICT_FILTERED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_WIPE;
      wipe_ptr       <= '0;
      epoch          <= EPOCH_FIRST;
      hit_count      <= '0;
      new_count      <= '0;
      run_length     <= '0;
      qualified_runs <= '0;
      overflowed     <= 1'b0;
      wb_rd_v        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && verdicts.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_WIPE: begin
          wipe_ptr <= wipe_ptr + 1'b1;
          if (wipe_ptr == MAP_AW'(HIT_SPACE - 1)) begin
            wipe_ptr <= '0;
            epoch    <= EPOCH_FIRST;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (pop) begin
            if (head.entry.op == OP_CLEAR) begin
              hit_count      <= '0;
              new_count      <= '0;
              run_length     <= '0;
              qualified_runs <= '0;
              overflowed     <= 1'b0;
              if (epoch == EPOCH_LAST) begin
                state <= S_WIPE;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end else begin
              last_q     <= (head.entry.op == OP_LAST);
              in_range_q <= head_in_range;
              if (buf_full) begin
                overflowed <= 1'b1;
              end else begin
                hit_count <= hit_count + 1'b1;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!covered) begin
            if (new_count != SAT9) begin
              new_count <= new_count + 1'b1;
            end
            if (run_length != SAT9) begin
              run_length <= run_length + 1'b1;
            end
          end else begin
            if (run_length >= cfg.run_threshold && qualified_runs != SAT8) begin
              qualified_runs <= qualified_runs + 1'b1;
            end
            run_length <= '0;
          end
          state <= last_q ? S_JUDGE : S_FETCH;
        end
        S_JUDGE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_verdict    <= verdict;
            out_len        <= REG_W'(hit_count);
            out_new        <= new_count;
            out_runs       <= runs_final;
            hit_count      <= '0;
            new_count      <= '0;
            run_length     <= '0;
            qualified_runs <= '0;
            overflowed     <= 1'b0;
            wb_ptr         <= '0;
            wb_len         <= hit_count;
            state          <= (verdict == VERDICT_ACCEPTED) ? S_WB : S_FETCH;
          end
        end
        S_WB: begin
          wb_rd_v <= (wb_ptr != wb_len);
          if (wb_ptr != wb_len) begin
            wb_ptr <= wb_ptr + 1'b1;
          end else begin
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_WIPE;
        end
      endcase
    end
  end

  assign verdicts.valid         = out_valid;
  assign verdicts.verdict       = out_verdict;
  assign verdicts.track_length  = out_len;
  assign verdicts.new_hit_count = out_new;
  assign verdicts.run_count     = out_runs;

endmodule

@@ hw/rtl/tcf_checker.sv @@
module tcf_checker import tcf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        verdict,
  input logic [REG_W-1:0]  track_length,
  input logic [RUNS_W-1:0] run_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(verdict) && $stable(track_length) && $stable(run_count))
    else $error("verdict payload changed while stalled");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ACCEPTED |-> run_count != '0)
    else $error("accepted candidate without a qualifying run");

  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_OVERFLOW |-> track_length == REG_W'(MAX_TRACK_LEN))
    else $error("overflow verdict with track length below the limit");

endmodule

bind track_coverage_filter_unit tcf_checker u_tcf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (verdicts.valid),
  .out_ready    (verdicts.ready),
  .verdict      (verdicts.verdict),
  .track_length (verdicts.track_length),
  .run_count    (verdicts.run_count)
);

@@ tb/sv/track_coverage_filter_unit_tb.sv @@
`timescale 1ns / 100ps

module track_coverage_filter_unit_tb;
  import tcf_pkg::*;

  localparam bit CMD_HIT   = 1'b0;
  localparam bit CMD_CLEAR = 1'b1;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = MAX_TRACK_LEN + 40;
  localparam int unsigned PHASE_ITEMS   = 12;
  localparam int unsigned COUNT_SAT     = 511;
  localparam int unsigned RUNS_SAT      = 255;

  typedef struct packed {
    verdict_t          verdict;
    logic [REG_W-1:0]  track_length;
    logic [REG_W-1:0]  new_hits;
    logic [RUNS_W-1:0] runs;
  } verdict_rec_t;

  typedef struct {
    int unsigned min_len;
    int unsigned thr;
    int unsigned ratio;
  } reg_set_t;

  class coverage_board;
    bit                     covered [HIT_SPACE];
    logic [HIT_INDEX_W-1:0] cand_hits [$];
    int unsigned            n_hits, n_new, cur_run, n_runs;
    bit                     overflowed;
    int unsigned            min_len, run_thr, ratio;
    verdict_rec_t           due_verdicts [$];
    int unsigned            errors;

    function new();
      min_len = 0;
      run_thr = 1;
      ratio   = 0;
      errors  = 0;
      drop_candidate();
    endfunction

    function void drop_candidate();
      cand_hits.delete();
      n_hits     = 0;
      n_new      = 0;
      cur_run    = 0;
      n_runs     = 0;
      overflowed = 1'b0;
    endfunction

    function void set_reg(reg_index_t r, logic [REG_W-1:0] v);
      case (r)
        REG_MIN_TRACK_LENGTH: min_len = 32'(v);
        REG_RUN_THRESHOLD:    run_thr = 32'(v);
        REG_NEW_RATIO_Q8:     ratio   = 32'(v);
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return due_verdicts.size();
    endfunction

    function void note_hit(bit cmd, logic [HIT_INDEX_W-1:0] idx, bit last);
      int unsigned  runs;
      verdict_rec_t rec;
      if (cmd == CMD_CLEAR) begin
        foreach (covered[i]) covered[i] = 1'b0;
        drop_candidate();
        return;
      end
      if (n_hits < MAX_TRACK_LEN) begin
        cand_hits = {cand_hits, idx};
        n_hits++;
      end else begin
        overflowed = 1'b1;
      end
      if (!covered[idx]) begin
        if (n_new < COUNT_SAT) n_new++;
        if (cur_run < COUNT_SAT) cur_run++;
      end else begin
        if (cur_run >= run_thr && n_runs < RUNS_SAT) n_runs++;
        cur_run = 0;
      end
      if (!last) return;
      runs = n_runs;
      if (cur_run >= run_thr && runs < RUNS_SAT) runs++;
      if (overflowed) begin
        rec.verdict = VERDICT_OVERFLOW;
      end else if (n_hits < min_len) begin
        rec.verdict = VERDICT_SHORT;
      end else if (n_new * 256 >= ratio * n_hits && runs > 0) begin
        rec.verdict = VERDICT_ACCEPTED;
      end else begin
        rec.verdict = VERDICT_FILTERED;
      end
      if (rec.verdict == VERDICT_ACCEPTED) begin
        foreach (cand_hits[i]) covered[cand_hits[i]] = 1'b1;
      end
      rec.track_length = REG_W'(n_hits);
      rec.new_hits     = REG_W'(n_new);
      rec.runs         = RUNS_W'(runs);
      due_verdicts = {due_verdicts, rec};
      drop_candidate();
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_verdict(verdict_rec_t got);
      verdict_rec_t exp_rec;
      if (due_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict transaction: expected none actual %0d/%0d/%0d/%0d",
                 $time, got.verdict, got.track_length, got.new_hits, got.runs);
        return;
      end
      exp_rec = due_verdicts.pop_front();
      compare_field("verdict", 32'(exp_rec.verdict), 32'(got.verdict));
      compare_field("track_length", 32'(exp_rec.track_length), 32'(got.track_length));
      compare_field("new_hit_count", 32'(exp_rec.new_hits), 32'(got.new_hits));
      compare_field("run_count", 32'(exp_rec.runs), 32'(got.runs));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  tcf_in_if  hits ();
  tcf_out_if verdicts ();

  coverage_board board = new();
  bit            calm = 1'b0;
  int unsigned   items_sent = 0;
  int unsigned   cycles = 0;

  track_coverage_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .hits      (hits),
    .verdicts  (verdicts)
  );

  always #5 clk = ~clk;

  initial begin
    hits.valid     = 1'b0;
    hits.command   = CMD_HIT;
    hits.hit_index = '0;
    hits.last_hit  = 1'b0;
    verdicts.ready = 1'b0;
    forever begin
      @(negedge clk);
      verdicts.ready = calm || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (!rst && verdicts.valid && verdicts.ready) begin
      board.check_verdict('{verdict_t'(verdicts.verdict), verdicts.track_length,
                            verdicts.new_hit_count, verdicts.run_count});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("track_coverage_filter_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(bit cmd, logic [HIT_INDEX_W-1:0] idx, bit last);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      hits.valid     = 1'b0;
      hits.command   = 1'($urandom_range(1));
      hits.hit_index = HIT_INDEX_W'($urandom);
      hits.last_hit  = 1'($urandom_range(1));
      repeat (gap) @(negedge clk);
    end
    hits.valid     = 1'b1;
    hits.command   = cmd;
    hits.hit_index = idx;
    hits.last_hit  = last;
    do @(posedge clk); while (!hits.ready);
    board.note_hit(cmd, idx, last);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    hits.valid = 1'b0;
    while (board.waiting() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(reg_set_t s);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_MIN_TRACK_LENGTH;
    cfg_wdata = REG_W'(s.min_len);
    board.set_reg(REG_MIN_TRACK_LENGTH, REG_W'(s.min_len));
    @(negedge clk);
    cfg_index = REG_RUN_THRESHOLD;
    cfg_wdata = REG_W'(s.thr);
    board.set_reg(REG_RUN_THRESHOLD, REG_W'(s.thr));
    @(negedge clk);
    cfg_index = REG_NEW_RATIO_Q8;
    cfg_wdata = REG_W'(s.ratio);
    board.set_reg(REG_NEW_RATIO_Q8, REG_W'(s.ratio));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // straight run of hits base, base+1, ... (indices wrap modulo period)
  task automatic send_track(logic [HIT_INDEX_W-1:0] base, int unsigned len,
                            int unsigned period);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(CMD_HIT, base + HIT_INDEX_W'(i % period), i == len - 1);
    end
  endtask

  // one event: optional clear, candidates longest first from a small pool, some cut by clears
  task automatic send_event();
    int unsigned            lens [$];
    int unsigned            n_cand;
    int unsigned            span;
    logic [HIT_INDEX_W-1:0] base;
    logic [HIT_INDEX_W-1:0] idx;
    bit                     abort;
    if ($urandom_range(99) < 45) begin
      send_item(CMD_CLEAR, HIT_INDEX_W'($urandom), 1'($urandom_range(1)));
    end
    n_cand = $urandom_range(1, 4);
    for (int unsigned c = 0; c < n_cand; c++) begin
      lens = {lens, ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10)};
    end
    lens.rsort();
    base = HIT_INDEX_W'($urandom);
    span = $urandom_range(3, 40);
    foreach (lens[c]) begin
      abort = $urandom_range(99) < 6;
      for (int unsigned i = 0; i < lens[c]; i++) begin
        if (abort && i == lens[c] / 2) begin
          send_item(CMD_CLEAR, HIT_INDEX_W'($urandom), 1'($urandom_range(1)));
        end
        idx = ($urandom_range(9) == 0) ? HIT_INDEX_W'($urandom)
                                       : base + HIT_INDEX_W'($urandom_range(0, span - 1));
        send_item(CMD_HIT, idx, i == lens[c] - 1);
      end
    end
  endtask

  initial begin
    reg_set_t    plan [8];
    int unsigned start;
    plan[0] = '{2, 2, 128};
    plan[1] = '{0, 0, 256};
    plan[2] = '{3, 3, 192};
    plan[3] = '{1, 1, 64};
    plan[4] = '{511, 511, 511};
    plan[5] = '{0, 1, 511};
    plan[6] = '{$urandom_range(0, 8), $urandom_range(0, 5), $urandom_range(0, 320)};
    plan[7] = '{$urandom_range(0, 8), $urandom_range(0, 5), $urandom_range(0, 320)};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register values
    send_item(CMD_HIT, 16'h0000, 1'b1);
    send_item(CMD_HIT, 16'h0000, 1'b1);
    send_item(CMD_HIT, 16'hFFFF, 1'b0);
    send_item(CMD_HIT, 16'hFFFF, 1'b1);
    send_item(CMD_HIT, 16'h5555, 1'b0);
    send_item(CMD_HIT, 16'hAAAA, 1'b0);
    send_item(CMD_CLEAR, 16'h1234, 1'b1);
    send_item(CMD_HIT, 16'h0000, 1'b1);
    send_item(CMD_HIT, 16'h0000, 1'b0);
    send_item(CMD_HIT, 16'h0007, 1'b0);
    send_item(CMD_HIT, 16'h0008, 1'b0);
    send_item(CMD_HIT, 16'h0000, 1'b0);
    send_item(CMD_HIT, 16'h0009, 1'b1);
    send_item(CMD_CLEAR, 16'hFFFF, 1'b0);
    send_item(CMD_HIT, 16'h0001, 1'b1);
    send_item(CMD_HIT, 16'h00FF, 1'b0);
    send_item(CMD_HIT, 16'hFF00, 1'b1);

    // track past the buffer limit at the length and ratio extremes: overflow, saturated length
    program_regs('{256, 1, 256});
    send_track(16'h1000, MAX_TRACK_LEN + 4, MAX_TRACK_LEN);

    foreach (plan[p]) begin
      program_regs(plan[p]);
      calm  = (p == 2);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        send_event();
        if (p == 3 && items_sent - start >= PHASE_ITEMS / 2 && board.waiting() != 0) drain();
      end
    end
    calm = 1'b0;

    settle();
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("track_coverage_filter_unit_tb: PASS");
    end else begin
      $display("track_coverage_filter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_in_if.sv
hw/rtl/tcf_out_if.sv
hw/rtl/tcf_ram.sv
hw/rtl/tcf_front.sv
hw/rtl/tcf_queue.sv
hw/rtl/tcf_back.sv
hw/rtl/track_coverage_filter_unit.sv
hw/rtl/tcf_checker.sv
tb/sv/track_coverage_filter_unit_tb.sv
